[rtl/sws_pkg.sv]
// Shared types and constants for the stack with search.
package sws_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int CAP_W     = 5;
  localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic push_wr;
    logic push_full;
    logic pop_rd;
    logic pop_empty;
    logic pop_take;
    logic scan_start;
    logic scan_step;
    logic scan_hit;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  hit;
    logic  scan_last;
    logic  out_free;
  } stat_t;

endpackage

[rtl/sws_if.sv]
// Request and response channel interfaces for the stack with search.
interface sws_req_if
  import sws_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sws_rsp_if
  import sws_pkg::*;
#(
  parameter int CNT_W = CNT_W_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic                     found;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output data, output found, output status, output count,
                  input ready);
  modport sink   (input valid, input data, input found, input status, input count,
                  output ready);
endinterface

[rtl/stack_with_search.sv]
// Top level of the LIFO stack with linear search.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------
//   req     | in  | valid/ready   | func, value
//   rsp     | out | valid/ready   | data, found, status, count
//   cfg     | in  | cfg_we        | cfg_wdata (capacity)
//
// A pop waits on the registered memory read. A search compares entries one per cycle through
// the single read port and stops at the first match. Push, no-op, and pop or search of an
// empty stack need no memory read.
// The next request is accepted once the result sits in the output register, even while
// that result still waits to be taken; a stalled response holds that register.
// Reset clears the count and controller state and sets capacity to 16, not the memory.
module stack_with_search
  import sws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [CAP_W-1:0]   cfg_wdata,
  sws_req_if.sink           req,
  sws_rsp_if.source         rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t  cmd;
  stat_t stat;

  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sws_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_func    (req.func),
    .in_value   (req.value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_data   (rsp.data),
    .out_found  (rsp.found),
    .out_status (rsp.status),
    .out_count  (rsp.count)
  );

endmodule

[rtl/sws_ctrl.sv]
// Controller state machine: sequences push, pop and search requests.
module sws_ctrl
  import sws_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.func)
          FUNC_POP:    state_next = stat.empty ? S_DONE : S_READ;
          FUNC_SEARCH: state_next = stat.empty ? S_DONE : S_SCAN;
          default:     state_next = S_DONE;
        endcase
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        // Hold off requests while reset is asserted
        req_ready  = !rst;
        cmd.accept = req_valid && !rst;
      end
      S_EXEC: begin
        unique case (stat.func)
          FUNC_PUSH: begin
            cmd.push_full = stat.full;
            cmd.push_wr   = !stat.full;
          end
          FUNC_POP: begin
            cmd.pop_empty = stat.empty;
            cmd.pop_rd    = !stat.empty;
          end
          FUNC_SEARCH: begin
            cmd.scan_start = !stat.empty;
          end
          default: ;
        endcase
      end
      S_READ: begin
        cmd.pop_take = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_hit  = stat.hit;
        cmd.scan_step = !stat.hit && !stat.scan_last;
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/sws_dp.sv]
// Datapath: entry memory, count, capacity register, compare and result register.
module sws_dp
  import sws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_found,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  func_t             req_func;
  logic [DATA_W-1:0] req_value;
  logic [ADDR_W-1:0] scan_idx;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] res_data;
  logic              res_found;
  status_t           res_status;

  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  count_dec;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  // Clamp capacity into one to DEPTH
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign count_dec = count - CNT_W'(1);

  // Status toward the controller
  always_comb begin
    stat.func      = req_func;
    stat.full      = CMP_W'(count) >= eff_cap;
    stat.empty     = count == '0;
    stat.hit       = rd_data == req_value;
    stat.scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == count;
    stat.out_free  = !out_valid || out_ready;
  end

  // Select read address: top entry on pop, next scan slot on search
  always_comb begin
    rd_en = cmd.pop_rd || cmd.scan_start || cmd.scan_step;
    if (cmd.pop_rd) begin
      rd_addr = count_dec[ADDR_W-1:0];
    end else if (cmd.scan_start) begin
      rd_addr = '0;
    end else begin
      rd_addr = scan_idx + ADDR_W'(1);
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[count[ADDR_W-1:0]] <= req_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Capacity register and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (cmd.push_wr) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_rd) begin
        count <= count_dec;
      end
    end
  end

  // Latch request, track scan position, build result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func   <= func_t'(in_func);
      req_value  <= in_value;
      res_data   <= '0;
      res_found  <= 1'b0;
      res_status <= ST_OK;
    end
    if (cmd.push_full) res_status <= ST_FULL;
    if (cmd.pop_empty) res_status <= ST_EMPTY;
    if (cmd.pop_take)  res_data   <= rd_data;
    if (cmd.scan_hit)  res_found  <= 1'b1;
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= rd_addr;
    end
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data   <= res_data;
      out_found  <= res_found;
      out_status <= res_status;
      out_count  <= count;
    end
  end

endmodule
